@@ rtl/zba_pkg.sv @@
// Shared constants, types and codes of the zone bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none

package zba_pkg;

  localparam int BITS_PER_MAP  = 8192;
  localparam int MAX_MAPS      = 8;
  localparam int WORD_W        = 32;
  localparam int WORDS_PER_MAP = BITS_PER_MAP / WORD_W;
  localparam int STORE_WORDS   = MAX_MAPS * WORDS_PER_MAP;
  localparam int ADDR_W        = $clog2(STORE_WORDS);
  localparam int CNT_W         = ADDR_W + 1;
  localparam int BIT_W         = $clog2(WORD_W);
  localparam int MAP_SHIFT     = $clog2(BITS_PER_MAP);
  localparam int LIM_W         = $clog2(MAX_MAPS * BITS_PER_MAP) + 1;
  localparam int ZONE_W        = 16;
  localparam int BLK_W         = ZONE_W + 1;
  localparam int MAPB_W        = 4;
  localparam int LZS_W         = 3;
  localparam int FREE_W        = 23;
  localparam int STATUS_W      = 3;

  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [BIT_W-1:0]    pos_t;
  typedef logic [BIT_W:0]      ones_t;
  typedef logic [LIM_W-1:0]    lim_t;
  typedef logic [ZONE_W-1:0]   zone_t;
  typedef logic [BLK_W-1:0]    blk_t;
  typedef logic [MAPB_W-1:0]   mapb_t;
  typedef logic [FREE_W-1:0]   free_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_NOSPACE = 3'd1;
  localparam status_t ST_RANGE   = 3'd2;
  localparam status_t ST_ALREADY = 3'd3;
  localparam status_t ST_NOMAP   = 3'd4;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_COUNT = 2'd2,
    OP_LOAD  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_FIRST_DATA_ZONE = 2'd0,
    CFG_ZONE_COUNT      = 2'd1,
    CFG_MAP_BLOCKS      = 2'd2,
    CFG_LOG_ZONE_SIZE   = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FREE_CHK,
    S_FREE_BIT,
    S_SCAN,
    S_ALLOC_SET
  } state_t;

  typedef struct packed {
    logic  has_zero;
    pos_t  zero_pos;
    ones_t ones;
  } wu_res_t;

endpackage

`default_nettype wire

@@ rtl/zba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module zba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/zba_word_unit.sv @@
// Bitmap word unit: first clear bit and masked set-bit count of one word.
`timescale 1ns / 1ps
`default_nettype none

module zba_word_unit (
  input  wire zba_pkg::word_t   word,
  input  wire zba_pkg::word_t   mask,
  output      zba_pkg::wu_res_t res
);

  zba_pkg::word_t masked;
  zba_pkg::pos_t  pos;
  zba_pkg::ones_t ones;

  always_comb begin
    masked = word & mask;
    pos    = '0;
    ones   = '0;
    for (int i = zba_pkg::WORD_W - 1; i >= 0; i--) begin
      if (!word[i]) begin
        pos = zba_pkg::pos_t'(i);
      end
    end
    for (int i = 0; i < zba_pkg::WORD_W; i++) begin
      ones = ones + zba_pkg::ones_t'(masked[i]);
    end
    res.has_zero = ~&word;
    res.zero_pos = pos;
    res.ones     = ones;
  end

endmodule

`default_nettype wire

@@ rtl/zone_bitmap_allocator_core.sv @@
// Zone bitmap allocator: first-fit allocate, free, free count and bitmap load.
// The bitmap (2048 words of 32 bits) sits in one RAM with one read and one
// write port; allocate and count walk it one word per cycle through a single
// word unit. After reset a clearing pass zeroes all 2048 bitmap words with
// busy high; configuration writes are taken meanwhile. A load keeps busy
// low and returns its result in the next cycle. A free checks its range and
// map in S_FREE_CHK and ends there when either fails, else reads the word
// and clears the bit in S_FREE_BIT. A count or an allocate scans bitmap
// words (up to 2048, stopping at the first word with a clear bit for
// allocate); an allocate then sets that bit in S_ALLOC_SET. The result
// appears in the same cycle as busy falls. Each result appears on out_valid
// for exactly one cycle and cannot be held off by the receiver.
`timescale 1ns / 1ps
`default_nettype none

module zone_bitmap_allocator_core (
  input  wire  logic                    clk,
  input  wire  logic                    rst_n,
  input  wire  logic                    start,
  output       logic                    busy,
  input  wire  logic [1:0]              in_opcode,
  input  wire  logic [15:0]             in_block_number,
  input  wire  logic [10:0]             in_word_index,
  input  wire  logic [31:0]             in_word_data,
  output       logic                    out_valid,
  output       logic [2:0]              out_status,
  output       logic [15:0]             out_allocated_block,
  output       logic [22:0]             out_free_count,
  input  wire  logic                    cfg_we,
  input  wire  logic [1:0]              cfg_index,
  input  wire  logic [15:0]             cfg_wdata
);

  zba_pkg::state_t  state_r, state_nxt;
  zba_pkg::addr_t   clr_addr_r, clr_addr_nxt;
  zba_pkg::op_t     op_r, op_nxt;
  zba_pkg::zone_t   blk_r, blk_nxt;
  zba_pkg::cnt_t    issue_r, issue_nxt;
  zba_pkg::cnt_t    words_r, words_nxt;
  logic             chk_vld_r, chk_vld_nxt;
  zba_pkg::addr_t   chk_addr_r, chk_addr_nxt;
  zba_pkg::lim_t    limit_r, limit_nxt;
  zba_pkg::zone_t   used_r, used_nxt;
  zba_pkg::word_t   word_r, word_nxt;
  zba_pkg::addr_t   waddr_r, waddr_nxt;
  zba_pkg::pos_t    bit_r, bit_nxt;
  logic             out_valid_r, out_valid_nxt;
  zba_pkg::status_t out_status_r, out_status_nxt;
  zba_pkg::zone_t   out_block_r, out_block_nxt;
  zba_pkg::free_t   out_free_r, out_free_nxt;

  zba_pkg::zone_t   fdz_r;
  zba_pkg::zone_t   zc_r;
  zba_pkg::mapb_t   mapb_r;
  logic [2:0]       lzs_r;

  logic             ram_we;
  zba_pkg::addr_t   ram_waddr;
  zba_pkg::word_t   ram_wdata;
  zba_pkg::addr_t   ram_raddr;
  zba_pkg::word_t   ram_rdata;

  zba_pkg::mapb_t   present;
  zba_pkg::cnt_t    alloc_words;
  zba_pkg::lim_t    map_cap;
  zba_pkg::lim_t    limit_c;
  zba_pkg::cnt_t    count_words;
  logic             range_bad;
  zba_pkg::blk_t    zone;
  logic             no_map;
  zba_pkg::pos_t    rest;
  logic             last_part;
  zba_pkg::word_t   cnt_mask;
  zba_pkg::wu_res_t wu;
  zba_pkg::zone_t   cnt_diff;
  logic [zba_pkg::ADDR_W+zba_pkg::BIT_W-1:0] gidx;
  zba_pkg::blk_t    alloc_blk;

  zba_ram #(
    .WIDTH(zba_pkg::WORD_W),
    .DEPTH(zba_pkg::STORE_WORDS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  zba_word_unit u_wu (
    .word(ram_rdata),
    .mask(cnt_mask),
    .res (wu)
  );

  always_comb begin
    present     = (mapb_r > zba_pkg::mapb_t'(zba_pkg::MAX_MAPS)) ?
                  zba_pkg::mapb_t'(zba_pkg::MAX_MAPS) : mapb_r;
    alloc_words = zba_pkg::cnt_t'(present) * zba_pkg::cnt_t'(zba_pkg::WORDS_PER_MAP);
    map_cap     = zba_pkg::lim_t'(present) * zba_pkg::lim_t'(zba_pkg::BITS_PER_MAP);
    limit_c     = (zba_pkg::lim_t'(zc_r) < map_cap) ? zba_pkg::lim_t'(zc_r) : map_cap;
    count_words = zba_pkg::cnt_t'(limit_c >> zba_pkg::BIT_W) +
                  zba_pkg::cnt_t'(|limit_c[zba_pkg::BIT_W-1:0]);
    range_bad   = (blk_r < fdz_r) || (blk_r >= zc_r);
    zone        = zba_pkg::blk_t'(blk_r) - zba_pkg::blk_t'(fdz_r) + zba_pkg::blk_t'(1);
    no_map      = (zone >> zba_pkg::MAP_SHIFT) >= zba_pkg::blk_t'(present);
    rest        = limit_r[zba_pkg::BIT_W-1:0];
    last_part   = (rest != '0) &&
                  (zba_pkg::cnt_t'(chk_addr_r) ==
                   zba_pkg::cnt_t'(limit_r >> zba_pkg::BIT_W));
    cnt_mask    = last_part ? ((zba_pkg::word_t'(1) << rest) - zba_pkg::word_t'(1)) : '1;
    cnt_diff    = zc_r - used_r;
    gidx        = {waddr_r, bit_r};
    alloc_blk   = zba_pkg::blk_t'(gidx) + zba_pkg::blk_t'(fdz_r) - zba_pkg::blk_t'(1);
  end

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    op_nxt         = op_r;
    blk_nxt        = blk_r;
    issue_nxt      = issue_r;
    words_nxt      = words_r;
    chk_vld_nxt    = chk_vld_r;
    chk_addr_nxt   = chk_addr_r;
    limit_nxt      = limit_r;
    used_nxt       = used_r;
    word_nxt       = word_r;
    waddr_nxt      = waddr_r;
    bit_nxt        = bit_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_block_nxt  = out_block_r;
    out_free_nxt   = out_free_r;
    ram_we         = 1'b0;
    ram_waddr      = waddr_r;
    ram_wdata      = word_r;
    ram_raddr      = issue_r[zba_pkg::ADDR_W-1:0];

    case (state_r)
      zba_pkg::S_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + zba_pkg::addr_t'(1);
        if (clr_addr_r == zba_pkg::addr_t'(zba_pkg::STORE_WORDS - 1)) begin
          state_nxt = zba_pkg::S_IDLE;
        end
      end
      zba_pkg::S_IDLE: begin
        if (start) begin
          op_nxt      = zba_pkg::op_t'(in_opcode);
          blk_nxt     = in_block_number;
          issue_nxt   = '0;
          chk_vld_nxt = 1'b0;
          used_nxt    = '0;
          limit_nxt   = limit_c;
          case (zba_pkg::op_t'(in_opcode))
            zba_pkg::OP_ALLOC: begin
              words_nxt = alloc_words;
              state_nxt = zba_pkg::S_SCAN;
            end
            zba_pkg::OP_COUNT: begin
              words_nxt = count_words;
              state_nxt = zba_pkg::S_SCAN;
            end
            zba_pkg::OP_FREE: begin
              state_nxt = zba_pkg::S_FREE_CHK;
            end
            default: begin
              ram_we         = 1'b1;
              ram_waddr      = in_word_index;
              ram_wdata      = in_word_data;
              out_valid_nxt  = 1'b1;
              out_status_nxt = zba_pkg::ST_OK;
              out_block_nxt  = '0;
              out_free_nxt   = '0;
            end
          endcase
        end
      end
      zba_pkg::S_FREE_CHK: begin
        out_block_nxt = '0;
        out_free_nxt  = '0;
        if (range_bad) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = zba_pkg::ST_RANGE;
          state_nxt      = zba_pkg::S_IDLE;
        end else if (no_map) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = zba_pkg::ST_NOMAP;
          state_nxt      = zba_pkg::S_IDLE;
        end else begin
          ram_raddr = zba_pkg::addr_t'(zone >> zba_pkg::BIT_W);
          waddr_nxt = zba_pkg::addr_t'(zone >> zba_pkg::BIT_W);
          bit_nxt   = zone[zba_pkg::BIT_W-1:0];
          state_nxt = zba_pkg::S_FREE_BIT;
        end
      end
      zba_pkg::S_FREE_BIT: begin
        out_valid_nxt = 1'b1;
        out_block_nxt = '0;
        out_free_nxt  = '0;
        state_nxt     = zba_pkg::S_IDLE;
        if (!ram_rdata[bit_r]) begin
          out_status_nxt = zba_pkg::ST_ALREADY;
        end else begin
          ram_we         = 1'b1;
          ram_waddr      = waddr_r;
          ram_wdata      = ram_rdata & ~(zba_pkg::word_t'(1) << bit_r);
          out_status_nxt = zba_pkg::ST_OK;
        end
      end
      zba_pkg::S_SCAN: begin
        if (chk_vld_r && (op_r == zba_pkg::OP_ALLOC) && wu.has_zero) begin
          word_nxt    = ram_rdata;
          waddr_nxt   = chk_addr_r;
          bit_nxt     = wu.zero_pos;
          chk_vld_nxt = 1'b0;
          state_nxt   = zba_pkg::S_ALLOC_SET;
        end else begin
          if (chk_vld_r && (op_r == zba_pkg::OP_COUNT)) begin
            used_nxt = used_r + zba_pkg::zone_t'(wu.ones);
          end
          if (issue_r < words_r) begin
            ram_raddr    = issue_r[zba_pkg::ADDR_W-1:0];
            chk_vld_nxt  = 1'b1;
            chk_addr_nxt = issue_r[zba_pkg::ADDR_W-1:0];
            issue_nxt    = issue_r + zba_pkg::cnt_t'(1);
          end else begin
            chk_vld_nxt = 1'b0;
            if (!chk_vld_r) begin
              out_valid_nxt = 1'b1;
              out_block_nxt = '0;
              state_nxt     = zba_pkg::S_IDLE;
              if (op_r == zba_pkg::OP_COUNT) begin
                out_status_nxt = zba_pkg::ST_OK;
                out_free_nxt   = zba_pkg::free_t'(cnt_diff) << lzs_r;
              end else begin
                out_status_nxt = zba_pkg::ST_NOSPACE;
                out_free_nxt   = '0;
              end
            end
          end
        end
      end
      zba_pkg::S_ALLOC_SET: begin
        ram_we        = 1'b1;
        ram_waddr     = waddr_r;
        ram_wdata     = word_r | (zba_pkg::word_t'(1) << bit_r);
        out_valid_nxt = 1'b1;
        out_free_nxt  = '0;
        state_nxt     = zba_pkg::S_IDLE;
        if ((gidx == '0) || (alloc_blk >= zba_pkg::blk_t'(zc_r))) begin
          out_status_nxt = zba_pkg::ST_RANGE;
          out_block_nxt  = '0;
        end else begin
          out_status_nxt = zba_pkg::ST_OK;
          out_block_nxt  = alloc_blk[zba_pkg::ZONE_W-1:0];
        end
      end
      default: begin
        state_nxt = zba_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= zba_pkg::S_CLEAR;
      clr_addr_r  <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      fdz_r       <= '0;
      zc_r        <= '0;
      mapb_r      <= '0;
      lzs_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (zba_pkg::cfg_idx_t'(cfg_index))
          zba_pkg::CFG_FIRST_DATA_ZONE: fdz_r  <= cfg_wdata;
          zba_pkg::CFG_ZONE_COUNT:      zc_r   <= cfg_wdata;
          zba_pkg::CFG_MAP_BLOCKS:      mapb_r <= cfg_wdata[zba_pkg::MAPB_W-1:0];
          default:                      lzs_r  <= cfg_wdata[zba_pkg::LZS_W-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    blk_r        <= blk_nxt;
    issue_r      <= issue_nxt;
    words_r      <= words_nxt;
    chk_addr_r   <= chk_addr_nxt;
    limit_r      <= limit_nxt;
    used_r       <= used_nxt;
    word_r       <= word_nxt;
    waddr_r      <= waddr_nxt;
    bit_r        <= bit_nxt;
    out_status_r <= out_status_nxt;
    out_block_r  <= out_block_nxt;
    out_free_r   <= out_free_nxt;
  end

  assign busy                = (state_r != zba_pkg::S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_allocated_block = out_block_r;
  assign out_free_count      = out_free_r;

endmodule

`default_nettype wire

@@ rtl/zba_checker.sv @@
// Port-level checker for the zone bitmap allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module zba_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [1:0]  in_opcode,
  input wire logic        out_valid,
  input wire logic [2:0]  out_status,
  input wire logic [15:0] out_allocated_block,
  input wire logic [22:0] out_free_count
);

  a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_opcode == zba_pkg::OP_LOAD)) |=>
      (out_valid && (out_status == zba_pkg::ST_OK)))
    else $error("load transaction did not complete in one cycle");

  a_long_op_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_opcode != zba_pkg::OP_LOAD)) |=> (busy && !out_valid))
    else $error("operation did not hold busy");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) ||
                   ($past(start) && ($past(in_opcode) == zba_pkg::OP_LOAD))))
    else $error("result without a transaction");

  a_payload_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_allocated_block != '0) || (out_free_count != '0))) |->
      ((out_status == zba_pkg::ST_OK) &&
       ((out_allocated_block == '0) || (out_free_count == '0))))
    else $error("result payload inconsistent with status");

endmodule

bind zone_bitmap_allocator_core zba_checker u_zba_checker (.*);

`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for the zone bitmap allocator core.
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    zba_pkg::status_t status;
    zba_pkg::zone_t   block;
    zba_pkg::free_t   count;
  } zone_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_opcode;
  logic [15:0] in_block_number;
  logic [10:0] in_word_index;
  logic [31:0] in_word_data;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [15:0] out_allocated_block;
  logic [22:0] out_free_count;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  zba_pkg::word_t zone_mirror [zba_pkg::STORE_WORDS];
  zba_pkg::zone_t cur_first_zone;
  zba_pkg::zone_t cur_zones;
  zba_pkg::mapb_t cur_maps;
  logic [2:0]     cur_log_zone;
  zone_result_t   expected_q [$];
  zone_result_t   last_predicted;
  zone_result_t   head;
  zba_pkg::zone_t live_blocks [$];
  int             errors;
  bit             no_gaps;

  zone_bitmap_allocator_core u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_opcode           (in_opcode),
    .in_block_number     (in_block_number),
    .in_word_index       (in_word_index),
    .in_word_data        (in_word_data),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_allocated_block (out_allocated_block),
    .out_free_count      (out_free_count),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("zone_bitmap_allocator_core test failed");
    $finish;
  end

  function automatic int unsigned maps_present();
    return (cur_maps > zba_pkg::MAX_MAPS) ? zba_pkg::MAX_MAPS : cur_maps;
  endfunction

  function automatic zone_result_t apply_op(zba_pkg::op_t op, zba_pkg::zone_t blk,
                                            zba_pkg::addr_t widx, zba_pkg::word_t data);
    zone_result_t r;
    int unsigned  words;
    int unsigned  g;
    int unsigned  target;
    int unsigned  zone;
    int unsigned  limit;
    int unsigned  used;
    bit           found;
    r = '0;
    r.status = zba_pkg::ST_OK;
    case (op)
      zba_pkg::OP_ALLOC: begin
        r.status = zba_pkg::ST_NOSPACE;
        found = 1'b0;
        words = maps_present() * zba_pkg::WORDS_PER_MAP;
        for (int unsigned w = 0; w < words && !found; w++) begin
          for (int b = 0; b < zba_pkg::WORD_W && !found; b++) begin
            if (!zone_mirror[w][b]) begin
              found = 1'b1;
              zone_mirror[w][b] = 1'b1;
              g = w * zba_pkg::WORD_W + b;
              target = g + cur_first_zone - 1;
              if (g == 0 || target >= cur_zones) begin
                r.status = zba_pkg::ST_RANGE;
              end else begin
                r.status = zba_pkg::ST_OK;
                r.block = target[15:0];
              end
            end
          end
        end
      end
      zba_pkg::OP_FREE: begin
        if (blk < cur_first_zone || blk >= cur_zones) begin
          r.status = zba_pkg::ST_RANGE;
        end else begin
          zone = blk - cur_first_zone + 1;
          if (zone / zba_pkg::BITS_PER_MAP >= maps_present()) begin
            r.status = zba_pkg::ST_NOMAP;
          end else if (!zone_mirror[zone >> 5][zone & 31]) begin
            r.status = zba_pkg::ST_ALREADY;
          end else begin
            zone_mirror[zone >> 5][zone & 31] = 1'b0;
          end
        end
      end
      zba_pkg::OP_COUNT: begin
        limit = maps_present() * zba_pkg::BITS_PER_MAP;
        if (cur_zones < limit) limit = cur_zones;
        used = 0;
        for (int unsigned w = 0; w < (limit >> 5); w++) used += $countones(zone_mirror[w]);
        if ((limit & 31) != 0)
          used += $countones(zone_mirror[limit >> 5] & ((32'd1 << (limit & 31)) - 32'd1));
        g = (cur_zones - used) << cur_log_zone;
        r.count = g[zba_pkg::FREE_W-1:0];
      end
      default: begin
        zone_mirror[widx] = data;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $error("result with no transaction pending: status %0d", out_status);
        errors++;
      end else begin
        head = expected_q.pop_front();
        if (out_status !== head.status) begin
          $error("status: expected %0d, actual %0d", head.status, out_status);
          errors++;
        end
        if (out_allocated_block !== head.block) begin
          $error("allocated_block: expected %0d, actual %0d", head.block, out_allocated_block);
          errors++;
        end
        if (out_free_count !== head.count) begin
          $error("free_count: expected %0d, actual %0d", head.count, out_free_count);
          errors++;
        end
      end
    end
  end

  task automatic reset_dut();
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = zba_pkg::OP_ALLOC;
    in_block_number = '0;
    in_word_index = '0;
    in_word_data = '0;
    cfg_we = 1'b0;
    cfg_index = zba_pkg::CFG_FIRST_DATA_ZONE;
    cfg_wdata = '0;
    errors = 0;
    no_gaps = 1'b0;
    foreach (zone_mirror[i]) zone_mirror[i] = '0;
    cur_first_zone = '0;
    cur_zones = '0;
    cur_maps = '0;
    cur_log_zone = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  endtask

  task automatic set_reg(zba_pkg::cfg_idx_t idx, int unsigned val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val[15:0];
    case (idx)
      zba_pkg::CFG_FIRST_DATA_ZONE: cur_first_zone = val[15:0];
      zba_pkg::CFG_ZONE_COUNT:      cur_zones = val[15:0];
      zba_pkg::CFG_MAP_BLOCKS:      cur_maps = val[3:0];
      default:                      cur_log_zone = val[2:0];
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic configure(int unsigned first, int unsigned zones, int unsigned maps,
                           int unsigned lzs);
    set_reg(zba_pkg::CFG_FIRST_DATA_ZONE, first);
    set_reg(zba_pkg::CFG_ZONE_COUNT, zones);
    set_reg(zba_pkg::CFG_MAP_BLOCKS, maps);
    set_reg(zba_pkg::CFG_LOG_ZONE_SIZE, lzs);
  endtask

  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (expected_q.size() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic issue(zba_pkg::op_t op, zba_pkg::zone_t blk, zba_pkg::addr_t widx,
                       zba_pkg::word_t data);
    if (!no_gaps && $urandom_range(99) < 28) begin
      @(negedge clk);
      start = 1'b0;
      in_opcode = 2'($urandom_range(3));
      in_block_number = 16'($urandom);
      in_word_index = 11'($urandom);
      in_word_data = $urandom;
      repeat ($urandom_range(4)) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    in_opcode = op;
    in_block_number = blk;
    in_word_index = widx;
    in_word_data = data;
    while (busy) @(negedge clk);
    @(posedge clk);
    last_predicted = apply_op(op, blk, widx, data);
    expected_q.push_back(last_predicted);
  endtask

  task automatic test_unconfigured();
    issue(zba_pkg::OP_ALLOC, 16'd0, 11'd0, 32'd0);
    issue(zba_pkg::OP_FREE, 16'd0, 11'd0, 32'd0);
    issue(zba_pkg::OP_COUNT, 16'hFFFF, 11'h7FF, 32'hFFFF_FFFF);
    issue(zba_pkg::OP_LOAD, 16'd0, 11'd2047, 32'hFFFF_FFFF);
    settle();
  endtask

  task automatic test_alloc_free();
    configure(10, 100, 1, 0);
    issue(zba_pkg::OP_ALLOC, 16'd0, 11'd0, 32'd0);
    issue(zba_pkg::OP_ALLOC, 16'd0, 11'd0, 32'd0);
    issue(zba_pkg::OP_ALLOC, 16'd0, 11'd0, 32'd0);
    issue(zba_pkg::OP_FREE, 16'd10, 11'd0, 32'd0);
    issue(zba_pkg::OP_FREE, 16'd10, 11'd0, 32'd0);
    issue(zba_pkg::OP_FREE, 16'd9, 11'd0, 32'd0);
    issue(zba_pkg::OP_FREE, 16'd100, 11'd0, 32'd0);
    issue(zba_pkg::OP_COUNT, 16'd0, 11'd0, 32'd0);
    for (int w = 0; w < 4; w++) begin
      issue(zba_pkg::OP_LOAD, 16'd0, zba_pkg::addr_t'(w), 32'hFFFF_FFFF);
    end
    issue(zba_pkg::OP_ALLOC, 16'd0, 11'd0, 32'd0);
    settle();
    set_reg(zba_pkg::CFG_LOG_ZONE_SIZE, 7);
    issue(zba_pkg::OP_COUNT, 16'd0, 11'd0, 32'd0);
    settle();
  endtask

  task automatic test_map_limits();
    configure(0, 65535, 1, 7);
    issue(zba_pkg::OP_FREE, 16'd9000, 11'd0, 32'd0);
    settle();
    set_reg(zba_pkg::CFG_MAP_BLOCKS, 15);
    issue(zba_pkg::OP_FREE, 16'd9000, 11'd0, 32'd0);
    issue(zba_pkg::OP_COUNT, 16'd0, 11'd0, 32'd0);
    settle();
    set_reg(zba_pkg::CFG_FIRST_DATA_ZONE, 65535);
    issue(zba_pkg::OP_ALLOC, 16'd0, 11'd0, 32'd0);
    issue(zba_pkg::OP_FREE, 16'd65535, 11'd0, 32'd0);
    settle();
  endtask

  task automatic test_random_traffic();
    int unsigned    first;
    int unsigned    zones;
    int unsigned    maps;
    int unsigned    pick;
    int unsigned    idx;
    int             lo;
    int             hi;
    zba_pkg::zone_t blk;
    zba_pkg::addr_t widx;
    zba_pkg::word_t data;
    for (int p = 0; p < 6; p++) begin
      first = $urandom_range(0, 300);
      zones = (p == 3) ? 65535 : first + $urandom_range(50, 9000);
      if (p == 3) maps = 8;
      else if (p == 4) maps = $urandom_range(9, 15);
      else if (p == 5) maps = $urandom_range(0, 3);
      else maps = $urandom_range(1, 2);
      configure(first, zones, maps, $urandom_range(0, 7));
      no_gaps = (p == 2);
      for (int n = 0; n < 44; n++) begin
        pick = $urandom_range(99);
        blk = '0;
        widx = '0;
        data = '0;
        if (pick < 35) begin
          issue(zba_pkg::OP_ALLOC, blk, widx, data);
          if (last_predicted.status == zba_pkg::ST_OK) begin
            live_blocks.push_back(last_predicted.block);
          end
        end else if (pick < 65) begin
          if (live_blocks.size() != 0 && $urandom_range(99) < 75) begin
            idx = $urandom_range(live_blocks.size() - 1);
            blk = live_blocks[idx];
            live_blocks.delete(idx);
          end else if ($urandom_range(1)) begin
            lo = (first > 2) ? first - 2 : 0;
            hi = (zones + 2 > 65535) ? 65535 : zones + 2;
            blk = zba_pkg::zone_t'($urandom_range(hi, lo));
          end else begin
            blk = zba_pkg::zone_t'($urandom);
          end
          issue(zba_pkg::OP_FREE, blk, zba_pkg::addr_t'($urandom), $urandom);
        end else if (pick < 75) begin
          issue(zba_pkg::OP_COUNT, zba_pkg::zone_t'($urandom), zba_pkg::addr_t'($urandom),
                $urandom);
        end else begin
          widx = ($urandom_range(99) < 60) ? zba_pkg::addr_t'($urandom_range(0, 15)) :
                                             zba_pkg::addr_t'($urandom);
          data = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom;
          issue(zba_pkg::OP_LOAD, zba_pkg::zone_t'($urandom), widx, data);
        end
      end
      settle();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    reset_dut();
    test_unconfigured();
    test_alloc_free();
    test_map_limits();
    test_random_traffic();
    settle();
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("zone_bitmap_allocator_core test passed");
    end else begin
      $display("zone_bitmap_allocator_core test failed");
    end
    $finish;
  end

endmodule
